// ----- design/rc4_stream_cipher_macros.svh -----
// ----------------------------------------------------------------------------
// RC4 stream cipher assertion macros
// Shared concurrent assertion forms, clocked on aclk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RC4_STREAM_CIPHER_MACROS_SVH
`define RC4_STREAM_CIPHER_MACROS_SVH

// Same-cycle implication.
`define RC4_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RC4_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/rc4_pkg.sv -----
// ----------------------------------------------------------------------------
// RC4 package
// Sizes, operation and register codes, sequencer states and memory requests.
// ----------------------------------------------------------------------------
package rc4_pkg;

    localparam int STATE_SIZE  = 256;
    localparam int MAX_KEY_LEN = 256;
    localparam int BYTE_W      = 8;
    localparam int IDX_W       = $clog2(STATE_SIZE);
    localparam int KEY_AW      = $clog2(MAX_KEY_LEN);
    localparam int KLEN_W      = 9;
    localparam int SKIP_W      = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [KLEN_W-1:0] KEY_LENGTH_RESET = 9'd16;
    localparam logic [SKIP_W-1:0] SKIP_COUNT_RESET = 16'd0;

    localparam logic [1:0] OP_KEY_WRITE = 2'd0;
    localparam logic [1:0] OP_INIT      = 2'd1;
    localparam logic [1:0] OP_DATA      = 2'd2;
    localparam logic [1:0] OP_UNUSED    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SKIP_COUNT = 1'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_K0,
        ST_K1,
        ST_K2,
        ST_K3,
        ST_K4,
        ST_G0,
        ST_G1,
        ST_G2,
        ST_G3,
        ST_G4,
        ST_PUSH
    } ctrl_state_t;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [BYTE_W-1:0] wdata;
        logic [IDX_W-1:0]  raddr;
    } sbox_req_t;

    typedef struct packed {
        logic              we;
        logic [KEY_AW-1:0] waddr;
        logic [BYTE_W-1:0] wdata;
        logic [KEY_AW-1:0] raddr;
    } kstore_req_t;

endpackage

// ----- design/rc4_kstore.sv -----
// ----------------------------------------------------------------------------
// RC4 key store
// Key byte memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module rc4_kstore
    import rc4_pkg::*;
(
    input  logic              aclk,
    input  kstore_req_t       req,
    output logic [BYTE_W-1:0] rdata
);

    logic [BYTE_W-1:0] mem [MAX_KEY_LEN];

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        rdata <= mem[req.raddr];
    end

endmodule

// ----- design/rc4_sbox.sv -----
// ----------------------------------------------------------------------------
// RC4 permutation memory
// State table with one write port and one registered read port.
// ----------------------------------------------------------------------------
module rc4_sbox
    import rc4_pkg::*;
(
    input  logic              aclk,
    input  sbox_req_t         req,
    output logic [BYTE_W-1:0] rdata
);

    logic [BYTE_W-1:0] mem [STATE_SIZE];

    // A read at the address being written returns the old contents.
    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        rdata <= mem[req.raddr];
    end

endmodule

// ----- design/rc4_ctrl.sv -----
// ----------------------------------------------------------------------------
// RC4 sequencer
// Steps the key schedule, discard loop and keystream generation around one
// shared byte adder, and holds the result output register.
// ----------------------------------------------------------------------------
`include "rc4_stream_cipher_macros.svh"

module rc4_ctrl
    import rc4_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_op,
    input  logic [BYTE_W-1:0] s_value_byte,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [BYTE_W-1:0] m_result_byte,
    input  logic [KLEN_W-1:0] key_length,
    input  logic [SKIP_W-1:0] skip_count,
    output logic [KEY_AW-1:0] key_raddr,
    input  logic [BYTE_W-1:0] key_rdata,
    output sbox_req_t         sbox_req,
    input  logic [BYTE_W-1:0] sbox_rdata
);

    ctrl_state_t       state_reg, state_next;
    logic [IDX_W-1:0]  i_reg, i_next;
    logic [IDX_W-1:0]  j_reg, j_next;
    logic [IDX_W-1:0]  acc_reg, acc_next;
    logic [IDX_W-1:0]  n_reg, n_next;
    logic [KLEN_W-1:0] kpos_reg, kpos_next;
    logic [BYTE_W-1:0] sa_reg, sa_next;
    logic [IDX_W-1:0]  t_reg, t_next;
    logic              fwd_reg, fwd_next;
    logic              skip_mode_reg, skip_mode_next;
    logic [SKIP_W-1:0] skip_cnt_reg, skip_cnt_next;
    logic [BYTE_W-1:0] val_reg, val_next;
    logic [BYTE_W-1:0] hold_reg, hold_next;
    logic              m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0] m_data_reg, m_data_next;

    logic [BYTE_W-1:0] add_a, add_b, add_sum;
    logic [KLEN_W-1:0] kpos_inc;
    logic [BYTE_W-1:0] res_byte;
    logic              out_free;
    logic              accept;

    // The shared byte adder behind the i, j and t updates and the key schedule sum.
    assign add_sum  = add_a + add_b;
    assign kpos_inc = kpos_reg + KLEN_W'(1);
    assign out_free = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;
    assign res_byte = val_reg ^ (fwd_reg ? sa_reg : sbox_rdata);

    assign key_raddr     = kpos_reg[KEY_AW-1:0];
    assign m_valid       = m_valid_reg;
    assign m_result_byte = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            skip_mode_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            skip_mode_reg <= skip_mode_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg      <= acc_next;
        n_reg        <= n_next;
        kpos_reg     <= kpos_next;
        sa_reg       <= sa_next;
        t_reg        <= t_next;
        fwd_reg      <= fwd_next;
        skip_cnt_reg <= skip_cnt_next;
        val_reg      <= val_next;
        hold_reg     <= hold_next;
        m_data_reg   <= m_data_next;
    end

    always_comb begin
        state_next     = state_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        acc_next       = acc_reg;
        n_next         = n_reg;
        kpos_next      = kpos_reg;
        sa_next        = sa_reg;
        t_next         = t_reg;
        fwd_next       = fwd_reg;
        skip_mode_next = skip_mode_reg;
        skip_cnt_next  = skip_cnt_reg;
        val_next       = val_reg;
        hold_next      = hold_reg;
        m_data_next    = m_data_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        s_ready        = 1'b0;
        sbox_req       = '0;
        add_a          = i_reg;
        add_b          = BYTE_W'(1);

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (accept) begin
                    unique case (s_op)
                        OP_INIT: begin
                            n_next     = '0;
                            state_next = ST_FILL;
                        end
                        OP_DATA: begin
                            val_next       = s_value_byte;
                            skip_mode_next = 1'b0;
                            state_next     = ST_G0;
                        end
                        OP_KEY_WRITE, OP_UNUSED: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_FILL: begin
                sbox_req.we    = 1'b1;
                sbox_req.waddr = n_reg;
                sbox_req.wdata = n_reg;
                n_next         = n_reg + IDX_W'(1);
                if (n_reg == '1) begin
                    acc_next   = '0;
                    kpos_next  = '0;
                    state_next = ST_K0;
                end
            end
            ST_K0: begin
                sbox_req.raddr = n_reg;
                state_next     = ST_K1;
            end
            ST_K1: begin
                sa_next    = sbox_rdata;
                add_a      = acc_reg;
                add_b      = sbox_rdata;
                acc_next   = add_sum;
                state_next = ST_K2;
            end
            ST_K2: begin
                add_a          = acc_reg;
                add_b          = key_rdata;
                acc_next       = add_sum;
                sbox_req.raddr = add_sum;
                state_next     = ST_K3;
            end
            ST_K3: begin
                sbox_req.we    = 1'b1;
                sbox_req.waddr = n_reg;
                sbox_req.wdata = sbox_rdata;
                state_next     = ST_K4;
            end
            ST_K4: begin
                sbox_req.we    = 1'b1;
                sbox_req.waddr = acc_reg;
                sbox_req.wdata = sa_reg;
                kpos_next      = (kpos_inc >= key_length) ? '0 : kpos_inc;
                n_next         = n_reg + IDX_W'(1);
                if (n_reg == '1) begin
                    i_next         = '0;
                    j_next         = '0;
                    skip_cnt_next  = skip_count;
                    skip_mode_next = 1'b1;
                    state_next     = (skip_count == '0) ? ST_IDLE : ST_G0;
                end else begin
                    state_next = ST_K0;
                end
            end
            ST_G0: begin
                i_next         = add_sum;
                sbox_req.raddr = add_sum;
                state_next     = ST_G1;
            end
            ST_G1: begin
                sa_next        = sbox_rdata;
                add_a          = j_reg;
                add_b          = sbox_rdata;
                j_next         = add_sum;
                sbox_req.raddr = add_sum;
                state_next     = ST_G2;
            end
            ST_G2: begin
                sbox_req.we    = 1'b1;
                sbox_req.waddr = i_reg;
                sbox_req.wdata = sbox_rdata;
                add_a          = sa_reg;
                add_b          = sbox_rdata;
                t_next         = add_sum;
                state_next     = ST_G3;
            end
            ST_G3: begin
                // The read of entry t races the write of entry j.
                sbox_req.we    = 1'b1;
                sbox_req.waddr = j_reg;
                sbox_req.wdata = sa_reg;
                sbox_req.raddr = t_reg;
                fwd_next       = (t_reg == j_reg);
                if (skip_mode_reg) begin
                    skip_cnt_next = skip_cnt_reg - SKIP_W'(1);
                    state_next    = (skip_cnt_reg == SKIP_W'(1)) ? ST_IDLE : ST_G0;
                end else begin
                    state_next = ST_G4;
                end
            end
            ST_G4: begin
                if (out_free) begin
                    m_data_next  = res_byte;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end else begin
                    hold_next  = res_byte;
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (out_free) begin
                    m_data_next  = hold_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `RC4_ASSERT_NEXT(a_busy_after_data, accept && (s_op == OP_DATA), !s_ready, "ready during data beat")
    `RC4_ASSERT_IMPL(a_no_write_idle, state_reg == ST_IDLE, !sbox_req.we, "table write while idle")
    `RC4_ASSERT_IMPL(a_fill_wraps, ($past(state_reg) == ST_FILL) && (state_reg == ST_K0), n_reg == '0, "fill count did not wrap")
    `RC4_ASSERT_IMPL(a_result_source, $rose(m_valid_reg), ($past(state_reg) == ST_G4) || ($past(state_reg) == ST_PUSH), "result without keystream step")

endmodule

// ----- design/rc4_stream_cipher.sv -----
// ----------------------------------------------------------------------------
// RC4 stream cipher
// Drop-n RC4 with a key store, a two-port permutation memory and a small
// sequencer around one shared byte adder.
// ----------------------------------------------------------------------------
// A key-write beat (op 0) stores value_byte at key_index, and the block is
// ready again on the next cycle, so keys can be loaded at one byte per clock
// while idle. An init beat (op 1) keeps the block busy for the key schedule:
// a pass writes the identity into the permutation, then come the 256 mixing
// steps (ST_K0 to ST_K4 each) and one keystream step (ST_G0 to ST_G3) per
// discarded byte. A data beat (op 2) returns value_byte XOR one keystream
// byte after the states ST_G0 to ST_G4, and no new beat is taken until that
// byte has entered the result register. The steps come from the permutation
// memory, which has one read and one write port with a registered read: a
// keystream step needs two dependent reads, two swap writes and the output
// read, while one adder serves the i, j and t updates and the key schedule
// sum. Op 3 is accepted and ignored. The result register frees the input side
// from the result side; a result waiting to be taken only delays the next
// data byte at its last step. Configuration must be written while idle:
// index 0 sets key_length (9 bits), index 1 skip_count. The permutation holds
// no defined contents until the first init beat.
// ----------------------------------------------------------------------------
module rc4_stream_cipher
    import rc4_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_op,
    input  logic [KEY_AW-1:0]     s_key_index,
    input  logic [BYTE_W-1:0]     s_value_byte,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [BYTE_W-1:0]     m_result_byte,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic [KLEN_W-1:0] key_length_reg;
    logic [SKIP_W-1:0] skip_count_reg;
    kstore_req_t       kstore_req;
    logic [BYTE_W-1:0] key_rdata;
    logic [KEY_AW-1:0] key_raddr;
    sbox_req_t         sbox_req;
    logic [BYTE_W-1:0] sbox_rdata;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_length_reg <= KEY_LENGTH_RESET;
            skip_count_reg <= SKIP_COUNT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_KEY_LENGTH: key_length_reg <= cfg_wdata[KLEN_W-1:0];
                REG_SKIP_COUNT: skip_count_reg <= cfg_wdata[SKIP_W-1:0];
            endcase
        end
    end

    // Key bytes go straight into the key store on an accepted key-write beat.
    always_comb begin
        kstore_req.we    = s_valid && s_ready && (s_op == OP_KEY_WRITE);
        kstore_req.waddr = s_key_index;
        kstore_req.wdata = s_value_byte;
        kstore_req.raddr = key_raddr;
    end

    rc4_kstore u_kstore (
        .aclk  (aclk),
        .req   (kstore_req),
        .rdata (key_rdata)
    );

    rc4_sbox u_sbox (
        .aclk  (aclk),
        .req   (sbox_req),
        .rdata (sbox_rdata)
    );

    rc4_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_value_byte  (s_value_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_byte (m_result_byte),
        .key_length    (key_length_reg),
        .skip_count    (skip_count_reg),
        .key_raddr     (key_raddr),
        .key_rdata     (key_rdata),
        .sbox_req      (sbox_req),
        .sbox_rdata    (sbox_rdata)
    );

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// RC4 stream cipher testbench
// Drives key-write, init, data and unused beats through the cipher and checks
// every returned byte against a shadow RC4 generator or a known plan byte.
// ----------------------------------------------------------------------------
module testbench
    import rc4_pkg::*;
();

    // The longest stretch without any accepted beat is an init beat with the
    // largest skip count. The watchdog allows several times that.
    localparam int unsigned INIT_CYCLES_MAX = 6 * STATE_SIZE + 1 + 4 * 65535;
    localparam int unsigned WATCHDOG_LIMIT  = 4 * INIT_CYCLES_MAX;
    localparam int unsigned SETTLE_MARGIN   = 8;
    localparam int unsigned DRAIN_CYCLES    = 16;
    localparam int unsigned RANDOM_ITEMS    = 1500;
    localparam int unsigned MAX_REPORTS     = 10;
    localparam int          PLAN_ROWS       = 22;

    typedef enum logic {
        ROW_BEAT,
        ROW_CFG
    } row_kind_t;

    // One row of the directed plan. A configuration row uses reg_sel and
    // value; a beat row uses op, key_index and the low byte of value. When
    // has_known is set, the result byte is the one typed into the row.
    typedef struct {
        row_kind_t             kind;
        logic [1:0]            op;
        logic [KEY_AW-1:0]     key_index;
        logic [CFG_IDX_W-1:0]  reg_sel;
        logic [CFG_DATA_W-1:0] value;
        bit                    has_known;
        logic [BYTE_W-1:0]     known;
    } plan_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [1:0]            s_op;
    logic [KEY_AW-1:0]     s_key_index;
    logic [BYTE_W-1:0]     s_value_byte;
    logic                  m_valid;
    logic                  m_ready;
    logic [BYTE_W-1:0]     m_result_byte;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    // Shadow copy of the cipher state and its two registers.
    logic [BYTE_W-1:0]     sbox_shadow [STATE_SIZE];
    logic [BYTE_W-1:0]     key_shadow  [MAX_KEY_LEN];
    logic [IDX_W-1:0]      shadow_i;
    logic [IDX_W-1:0]      shadow_j;
    logic [KLEN_W-1:0]     shadow_key_len;
    logic [SKIP_W-1:0]     shadow_skip;

    // Result bytes still owed by the cipher, oldest first.
    logic [BYTE_W-1:0]     expected_bytes [$];

    plan_row_t             directed_plan [PLAN_ROWS];

    int unsigned           cycle_no = 0;
    int unsigned           busy_until = 0;
    int unsigned           failures = 0;
    bit                    src_idle_on;
    bit                    sink_idle_on;
    logic [BYTE_W-1:0]     want_byte;

    rc4_stream_cipher dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_key_index   (s_key_index),
        .s_value_byte  (s_value_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_byte (m_result_byte),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // The cycle count is updated with a nonblocking assignment so that any
    // process woken by the same edge reads the count from before the edge.
    always @(posedge aclk) begin
        cycle_no <= cycle_no + 1;
    end

    // ------------------------------------------------------------------------
    // Shadow RC4 generator
    // ------------------------------------------------------------------------
    task automatic swap_sbox(input logic [IDX_W-1:0] a, input logic [IDX_W-1:0] b);
        logic [BYTE_W-1:0] held;
        held = sbox_shadow[a];
        sbox_shadow[a] = sbox_shadow[b];
        sbox_shadow[b] = held;
    endtask

    // One generator step: advance i, add S[i] into j, swap, and look up the
    // keystream byte at S[i] + S[j]. All index arithmetic wraps at 8 bits.
    task automatic next_keystream_byte(output logic [BYTE_W-1:0] ks);
        logic [IDX_W-1:0] pick;
        shadow_i = shadow_i + 1'b1;
        shadow_j = shadow_j + sbox_shadow[shadow_i];
        swap_sbox(shadow_i, shadow_j);
        pick = sbox_shadow[shadow_i] + sbox_shadow[shadow_j];
        ks = sbox_shadow[pick];
    endtask

    // Key schedule followed by the discarded keystream bytes. The key position
    // is reset once it reaches key_length, which makes a length of zero act
    // like one and a length above the state size never wrap.
    task automatic run_key_schedule();
        int                n;
        int                kpos;
        logic [IDX_W-1:0]  acc;
        logic [BYTE_W-1:0] dropped;
        for (n = 0; n < STATE_SIZE; n++) begin
            sbox_shadow[n] = BYTE_W'(n);
        end
        acc = '0;
        kpos = 0;
        for (n = 0; n < STATE_SIZE; n++) begin
            acc = acc + sbox_shadow[n] + key_shadow[kpos % MAX_KEY_LEN];
            kpos++;
            if (kpos >= int'(shadow_key_len)) begin
                kpos = 0;
            end
            swap_sbox(IDX_W'(n), acc);
        end
        shadow_i = '0;
        shadow_j = '0;
        for (n = 0; n < int'(shadow_skip); n++) begin
            next_keystream_byte(dropped);
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Presents one beat after a random gap and returns at the edge that takes
    // it. The shadow state moves at that same edge. While the block works on
    // a beat that returns nothing, busy_until marks when it should be idle.
    task automatic send_beat(input logic [1:0] op, input logic [KEY_AW-1:0] kidx,
                             input logic [BYTE_W-1:0] val, input bit has_known,
                             input logic [BYTE_W-1:0] known);
        int unsigned       gap;
        int unsigned       settle;
        logic [BYTE_W-1:0] ks;
        gap = src_idle_on ? $urandom_range(0, 4) : 0;
        repeat (gap) begin
            @(negedge aclk);
            s_valid = 1'b0;
        end
        @(negedge aclk);
        s_valid      = 1'b1;
        s_op         = op;
        s_key_index  = kidx;
        s_value_byte = val;
        do @(posedge aclk); while (s_ready !== 1'b1);
        settle = SETTLE_MARGIN;
        case (op)
            OP_KEY_WRITE: begin
                key_shadow[kidx] = val;
            end
            OP_INIT: begin
                settle = 6 * STATE_SIZE + 1 + 4 * int'(shadow_skip) + SETTLE_MARGIN;
                run_key_schedule();
            end
            OP_DATA: begin
                next_keystream_byte(ks);
                expected_bytes.push_back(has_known ? known : (val ^ ks));
            end
            default: begin
                // The unused op leaves every piece of state alone.
            end
        endcase
        if (cycle_no + settle > busy_until) begin
            busy_until = cycle_no + settle;
        end
    endtask

    // Drops valid and waits until every owed byte has come back and any init
    // beat has had time to finish, so that a register may be written.
    task automatic wait_until_idle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (expected_bytes.size() != 0 || cycle_no < busy_until) begin
            @(posedge aclk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        if (idx == REG_KEY_LENGTH) begin
            shadow_key_len = data[KLEN_W-1:0];
        end else if (idx == REG_SKIP_COUNT) begin
            shadow_skip = data[SKIP_W-1:0];
        end
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    task automatic report_mismatch(input string what, input logic [BYTE_W-1:0] want,
                                   input logic [BYTE_W-1:0] got);
        failures++;
        if (failures <= MAX_REPORTS) begin
            $display("mismatch at cycle %0d: %s: expected %02h, got %02h",
                     cycle_no, what, want, got);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: the ready line and the checker
    // ------------------------------------------------------------------------

    // For each result the sink draws a stall. A nonzero stall drops ready,
    // waits for the next result to show up and holds it back for the stall drawn,
    // so the back pressure really lands on the result register.
    initial begin : result_sink
        int unsigned stall;
        wait (aresetn === 1'b1);
        forever begin
            stall = sink_idle_on ? $urandom_range(0, 4) : 0;
            if (stall != 0) begin
                @(negedge aclk);
                m_ready = 1'b0;
                while (m_valid !== 1'b1) begin
                    @(negedge aclk);
                end
                repeat (stall) @(negedge aclk);
                m_ready = 1'b1;
            end
            do @(posedge aclk); while (!(m_valid === 1'b1 && m_ready === 1'b1));
        end
    end

    // Every result beat is matched against the oldest owed byte.
    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (expected_bytes.size() == 0) begin
                report_mismatch("result beat with nothing owed", 'x, m_result_byte);
            end else begin
                want_byte = expected_bytes.pop_front();
                if (m_result_byte !== want_byte) begin
                    report_mismatch("result_byte", want_byte, m_result_byte);
                end
            end
        end
    end

    // The watchdog ends the run when no beat has moved on either channel for
    // far longer than the slowest init beat could take.
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid === 1'b1 && s_ready === 1'b1) ||
                (m_valid === 1'b1 && m_ready === 1'b1)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : main_flow
        int                unsigned items;
        int                unsigned phase_no;
        int                unsigned n_data;
        int                unsigned pick;
        int                k;
        int                d;
        int                eff_len;
        logic [KLEN_W-1:0] klen_pick;
        logic [SKIP_W-1:0] skip_pick;

        // Directed plan. The first block is the well-known three-byte key
        // "Key" with plaintext "Pla"; it only gives that ciphertext when the
        // skip count still holds its reset value of zero. After that come
        // the unused op, data bytes at both extremes, key writes at both ends
        // of the key store, a key length of zero with a one-byte skip, and a
        // second init on the same key to show the schedule restarts cleanly.
        directed_plan[0]  = '{ROW_CFG,  OP_UNUSED,    8'h00, REG_KEY_LENGTH, 16'd3,  1'b0, 8'h00};
        directed_plan[1]  = '{ROW_BEAT, OP_KEY_WRITE, 8'h00, REG_KEY_LENGTH, 16'h4B, 1'b0, 8'h00};
        directed_plan[2]  = '{ROW_BEAT, OP_KEY_WRITE, 8'h01, REG_KEY_LENGTH, 16'h65, 1'b0, 8'h00};
        directed_plan[3]  = '{ROW_BEAT, OP_KEY_WRITE, 8'h02, REG_KEY_LENGTH, 16'h79, 1'b0, 8'h00};
        directed_plan[4]  = '{ROW_BEAT, OP_INIT,      8'h5A, REG_KEY_LENGTH, 16'hA5, 1'b0, 8'h00};
        directed_plan[5]  = '{ROW_BEAT, OP_DATA,      8'h00, REG_KEY_LENGTH, 16'h50, 1'b1, 8'hBB};
        directed_plan[6]  = '{ROW_BEAT, OP_DATA,      8'h00, REG_KEY_LENGTH, 16'h6C, 1'b1, 8'hF3};
        directed_plan[7]  = '{ROW_BEAT, OP_DATA,      8'h00, REG_KEY_LENGTH, 16'h61, 1'b1, 8'h16};
        directed_plan[8]  = '{ROW_BEAT, OP_UNUSED,    8'hFF, REG_KEY_LENGTH, 16'hFF, 1'b0, 8'h00};
        directed_plan[9]  = '{ROW_BEAT, OP_DATA,      8'h00, REG_KEY_LENGTH, 16'h00, 1'b0, 8'h00};
        directed_plan[10] = '{ROW_BEAT, OP_DATA,      8'hFF, REG_KEY_LENGTH, 16'hFF, 1'b0, 8'h00};
        directed_plan[11] = '{ROW_BEAT, OP_KEY_WRITE, 8'hFF, REG_KEY_LENGTH, 16'hFF, 1'b0, 8'h00};
        directed_plan[12] = '{ROW_BEAT, OP_KEY_WRITE, 8'h00, REG_KEY_LENGTH, 16'h00, 1'b0, 8'h00};
        directed_plan[13] = '{ROW_CFG,  OP_UNUSED,    8'h00, REG_KEY_LENGTH, 16'd0,  1'b0, 8'h00};
        directed_plan[14] = '{ROW_CFG,  OP_UNUSED,    8'h00, REG_SKIP_COUNT, 16'd1,  1'b0, 8'h00};
        directed_plan[15] = '{ROW_BEAT, OP_INIT,      8'h00, REG_KEY_LENGTH, 16'h00, 1'b0, 8'h00};
        directed_plan[16] = '{ROW_BEAT, OP_DATA,      8'h00, REG_KEY_LENGTH, 16'hAA, 1'b0, 8'h00};
        directed_plan[17] = '{ROW_BEAT, OP_DATA,      8'h00, REG_KEY_LENGTH, 16'h55, 1'b0, 8'h00};
        directed_plan[18] = '{ROW_BEAT, OP_INIT,      8'hFF, REG_KEY_LENGTH, 16'hFF, 1'b0, 8'h00};
        directed_plan[19] = '{ROW_BEAT, OP_DATA,      8'h00, REG_KEY_LENGTH, 16'h00, 1'b0, 8'h00};
        directed_plan[20] = '{ROW_BEAT, OP_UNUSED,    8'h00, REG_KEY_LENGTH, 16'h00, 1'b0, 8'h00};
        directed_plan[21] = '{ROW_BEAT, OP_DATA,      8'h00, REG_KEY_LENGTH, 16'h3C, 1'b0, 8'h00};

        // Every input is known from time zero; reset is held before the plan starts.
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_op         = OP_KEY_WRITE;
        s_key_index  = '0;
        s_value_byte = '0;
        m_ready      = 1'b1;
        cfg_we       = 1'b0;
        cfg_index    = REG_KEY_LENGTH;
        cfg_wdata    = '0;

        for (k = 0; k < STATE_SIZE; k++) begin
            sbox_shadow[k] = '0;
            key_shadow[k]  = '0;
        end
        shadow_i       = '0;
        shadow_j       = '0;
        shadow_key_len = KEY_LENGTH_RESET;
        shadow_skip    = SKIP_COUNT_RESET;
        src_idle_on    = $urandom_range(0, 1) != 0;
        sink_idle_on   = $urandom_range(0, 1) != 0;

        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        for (k = 0; k < PLAN_ROWS; k++) begin
            if (directed_plan[k].kind == ROW_CFG) begin
                wait_until_idle();
                write_reg(directed_plan[k].reg_sel, directed_plan[k].value);
            end else begin
                send_beat(directed_plan[k].op, directed_plan[k].key_index,
                          directed_plan[k].value[BYTE_W-1:0],
                          directed_plan[k].has_known, directed_plan[k].known);
            end
        end

        // Random phases. Each phase picks a register setting while the block
        // is idle, loads every key byte the schedule will read with random
        // content, runs an init and then streams data. A small share of the
        // data stream is noise: unused ops, stray key writes that only matter
        // at the next init, and an init that restarts the stream midway.
        // The first three phases pin the extremes of the key length, and the
        // second one also carries the largest skip count.
        items = 0;
        phase_no = 0;
        while (items < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 15);
            case (pick)
                0:       klen_pick = '0;
                1:       klen_pick = KLEN_W'(STATE_SIZE);
                2:       klen_pick = KLEN_W'($urandom_range(STATE_SIZE + 1, (1 << KLEN_W) - 1));
                3, 4:    klen_pick = KLEN_W'($urandom_range(17, STATE_SIZE - 1));
                default: klen_pick = KLEN_W'($urandom_range(1, 16));
            endcase
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
                skip_pick = '0;
            end else if (pick < 9) begin
                skip_pick = SKIP_W'($urandom_range(1, 40));
            end else begin
                skip_pick = SKIP_W'($urandom_range(41, 400));
            end
            if (phase_no == 0) begin
                klen_pick = KLEN_W'(1);
                skip_pick = '0;
            end else if (phase_no == 1) begin
                klen_pick = KLEN_W'(STATE_SIZE);
                skip_pick = '1;
            end else if (phase_no == 2) begin
                klen_pick = '1;
            end

            wait_until_idle();
            write_reg(REG_KEY_LENGTH, CFG_DATA_W'(klen_pick));
            write_reg(REG_SKIP_COUNT, skip_pick);
            src_idle_on  = $urandom_range(0, 3) != 0;
            sink_idle_on = $urandom_range(0, 3) != 0;

            if (klen_pick == '0) begin
                eff_len = 1;
            end else if (int'(klen_pick) > STATE_SIZE) begin
                eff_len = STATE_SIZE;
            end else begin
                eff_len = int'(klen_pick);
            end
            for (k = 0; k < eff_len; k++) begin
                send_beat(OP_KEY_WRITE, KEY_AW'(k), BYTE_W'($urandom_range(0, 255)),
                          1'b0, '0);
            end
            send_beat(OP_INIT, KEY_AW'($urandom_range(0, 255)),
                      BYTE_W'($urandom_range(0, 255)), 1'b0, '0);
            items += eff_len + 1;

            n_data = $urandom_range(30, 90);
            for (d = 0; d < int'(n_data); d++) begin
                pick = $urandom_range(0, 99);
                if (pick < 4) begin
                    send_beat(OP_UNUSED, KEY_AW'($urandom_range(0, 255)),
                              BYTE_W'($urandom_range(0, 255)), 1'b0, '0);
                end else begin
                    if (pick < 7) begin
                        send_beat(OP_KEY_WRITE, KEY_AW'($urandom_range(0, 255)),
                                  BYTE_W'($urandom_range(0, 255)), 1'b0, '0);
                    end else if (pick < 9) begin
                        send_beat(OP_INIT, KEY_AW'($urandom_range(0, 255)),
                                  BYTE_W'($urandom_range(0, 255)), 1'b0, '0);
                    end else begin
                        send_beat(OP_DATA, KEY_AW'($urandom_range(0, 255)),
                                  BYTE_W'($urandom_range(0, 255)), 1'b0, '0);
                    end
                    items++;
                end
            end
            phase_no++;
        end

        // Let the last bytes drain, then keep watching the block for DRAIN_CYCLES in
        // case it emits anything it should not.
        wait_until_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (failures == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
